>>> hw/rtl/kls_pkg.sv
// Package for the keyframe linear sampler: request/response types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package kls_pkg;
    localparam int DEF_MAX_KEYS = 64;
    localparam int CNT_W        = 7;
    localparam int SLOT_W       = 6;
    localparam int VAL_W        = 32;

    localparam logic       REQ_LOAD   = 1'b0;
    localparam logic       REQ_SAMPLE = 1'b1;
    localparam logic [1:0] KIND_SCALAR = 2'd0;
    localparam logic [1:0] KIND_VECTOR = 2'd1;
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;
    localparam logic [1:0] COMP_BAD = 2'd3;
    localparam logic       REG_KEY_COUNT  = 1'b0;
    localparam logic       REG_VALUE_KIND = 1'b1;
    localparam logic       ST_OK  = 1'b0;
    localparam logic       ST_ERR = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [SLOT_W-1:0] key_slot;
        logic [31:0]       key_time;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic [31:0]       sample_tick;
        logic [1:0]        component;
    } req_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               status;
    } rsp_t;

    // classified sample job passed from front to back
    typedef struct packed {
        logic        err;
        logic [1:0]  sel;
        logic [31:0] tick;
    } job_t;
endpackage

>>> hw/rtl/kls_if.sv
// Valid/ready channel interfaces for the keyframe linear sampler.
// Depends on kls_pkg.
`timescale 1ns / 1ps
interface kls_req_if import kls_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface kls_rsp_if import kls_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface kls_cfg_if ();
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> hw/rtl/keyframe_linear_sampler.sv
// Top level of the keyframe linear sampler: config registers, front and back parts.
// Depends on kls_pkg, kls_if, kls_front, kls_back.
//
//  channel | dir | payload
//  --------+-----+--------------------------------------------
//  req     | in  | req_type, key_slot, key_time, key_x/y/z, tick, component
//  rsp     | out | sample_value, status
//  cfg     | in  | index (0 key_count, 1 value_kind), wdata
//
// A load is held until no sample is queued or in progress.
// A sample answered with an error goes straight to the response; one at or before the
// first key or at or after the last key takes that key's value; an interpolated one
// searches the keys in turn and then runs the bit-serial fraction divider.
// The back part handles one sample at a time; a two-entry queue lets the front
// keep accepting samples. Reset clears the config registers and control state;
// the table is undefined until loaded. A stalled response holds the back part.
`timescale 1ns / 1ps
module keyframe_linear_sampler
    import kls_pkg::*;
#(
    parameter int MAX_KEYS = DEF_MAX_KEYS
) (
    input logic        clk,
    input logic        rst_n,
    kls_req_if.sink    req,
    kls_rsp_if.source  rsp,
    kls_cfg_if.sink    cfg
);
    logic [CNT_W-1:0] key_count_reg;
    logic [1:0]       value_kind_reg;
    logic             wr_en, job_valid, job_pop, back_busy;
    job_t             job;

    // hold registers; the user must write them only while idle, the block does not check
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg  <= '0;
            value_kind_reg <= KIND_SCALAR;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KEY_COUNT:  key_count_reg  <= cfg.wdata[CNT_W-1:0];
                REG_VALUE_KIND: value_kind_reg <= cfg.wdata[1:0];
            endcase
        end
    end

    kls_front #(.MAX_KEYS(MAX_KEYS)) u_front (
        .clk, .rst_n,
        .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
        .key_count_n(key_count_reg), .value_kind(value_kind_reg),
        .back_busy, .wr_en, .job_data(job), .job_valid, .job_pop
    );

    kls_back #(.MAX_KEYS(MAX_KEYS)) u_back (
        .clk, .rst_n, .wr_en, .wr_data(req.data),
        .key_count_n(key_count_reg), .job_valid, .job_data(job), .job_pop,
        .busy(back_busy),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
    );

    // never pop an empty queue
    a_pop: assert property (@(posedge clk) disable iff (!rst_n) job_pop |-> job_valid)
        else $error("pop from empty job queue");
    // an error response carries zero
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status == ST_ERR) |-> (rsp.data.sample_value == 0))
        else $error("error response with nonzero value");
    // a held response stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid)
        else $error("response dropped");
endmodule

>>> hw/rtl/kls_front.sv
// Front part: accepts requests, classifies sample requests into jobs for a 2-entry queue.
// Depends on kls_pkg. Loads go out as table writes once the queue and back part are idle.
`timescale 1ns / 1ps
module kls_front
    import kls_pkg::*;
#(
    parameter int MAX_KEYS = DEF_MAX_KEYS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  req_t             in_data,
    input  logic [CNT_W-1:0] key_count_n,
    input  logic [1:0]       value_kind,
    input  logic             back_busy,
    output logic             wr_en,
    output job_t             job_data,
    output logic             job_valid,
    input  logic             job_pop
);
    job_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    job_t       nj;

    // hold a load until no sample is queued or in progress
    assign in_ready = (cnt_reg != 2'd2)
                      && ((in_data.req_type == REQ_SAMPLE) || (cnt_reg == 2'd0 && !back_busy));
    assign push     = in_valid && in_ready && (in_data.req_type == REQ_SAMPLE);
    assign wr_en    = in_valid && in_ready && (in_data.req_type == REQ_LOAD)
                      && ({{(32-SLOT_W){1'b0}}, in_data.key_slot} < 32'(MAX_KEYS));

    always_comb
    begin
        nj.tick = in_data.sample_tick;
        nj.sel  = (value_kind == KIND_VECTOR) ? in_data.component : COMP_X;
        nj.err  = (key_count_n == '0) || (value_kind != KIND_SCALAR && value_kind != KIND_VECTOR)
                  || (value_kind == KIND_VECTOR && in_data.component == COMP_BAD);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= nj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (job_pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(job_pop);
        end
    end

    assign job_valid = (cnt_reg != 2'd0);
    assign job_data  = q_reg[rp_reg];
endmodule

>>> hw/rtl/kls_back.sv
// Back part: key table memory, linear search, serial fraction divide, interpolation.
// Depends on kls_pkg.
`timescale 1ns / 1ps
module kls_back
    import kls_pkg::*;
#(
    parameter int MAX_KEYS = DEF_MAX_KEYS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  req_t             wr_data,
    input  logic [CNT_W-1:0] key_count_n,
    input  logic             job_valid,
    input  job_t             job_data,
    output logic             job_pop,
    output logic             busy,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp_data
);
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int IW = AW + 1;

    localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_CHK0 = 4'd2, S_RDL = 4'd3,
                           S_CHKL = 4'd4, S_SRCH = 4'd5, S_SCHK = 4'd6, S_PREV = 4'd7,
                           S_DIV = 4'd8, S_MUL = 4'd9, S_ADD = 4'd10, S_OUT = 4'd11,
                           S_PICK = 4'd12, S_HOLD = 4'd13;

    logic [31:0] mem_t [MAX_KEYS];
    logic [31:0] mem_x [MAX_KEYS];
    logic [31:0] mem_y [MAX_KEYS];
    logic [31:0] mem_z [MAX_KEYS];
    logic [31:0] rd_t_reg, rd_v_reg;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;

    logic [3:0]    st_reg;
    job_t          job_reg;
    logic [IW-1:0] n_reg, idx_reg;
    logic [31:0]   t1_reg, b_reg, a_reg;
    logic [48:0]   rem_reg;
    logic [16:0]   q_reg;
    logic [31:0]   span_reg;
    logic [5:0]    bit_reg;
    logic signed [49:0] prod_reg;
    logic [31:0]   res_reg;
    logic          err_reg;
    logic          ov_reg;

    logic [IW-1:0] cnt_clip;
    assign cnt_clip = (32'(key_count_n) > 32'(MAX_KEYS)) ? IW'(MAX_KEYS)
                      : IW'(key_count_n);

    assign waddr = AW'(wr_data.key_slot);

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_t[waddr] <= wr_data.key_time;
            mem_x[waddr] <= wr_data.key_x;
            mem_y[waddr] <= wr_data.key_y;
            mem_z[waddr] <= wr_data.key_z;
        end
        rd_t_reg <= mem_t[raddr];
        unique case (job_reg.sel)
            COMP_Y:  rd_v_reg <= mem_y[raddr];
            COMP_Z:  rd_v_reg <= mem_z[raddr];
            default: rd_v_reg <= mem_x[raddr];
        endcase
    end

    assign raddr   = idx_reg[AW-1:0];
    assign job_pop = (st_reg == S_IDLE) && job_valid;
    assign busy    = (st_reg != S_IDLE);

    logic signed [32:0] diff;
    logic signed [49:0] pfix;
    assign diff  = $signed({b_reg[31], b_reg}) - $signed({a_reg[31], a_reg});
    // floor divide by 2^16 (arithmetic shift floors toward minus infinity)
    assign pfix  = prod_reg >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            rsp_valid <= 1'b0;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        job_reg <= job_data;
                        n_reg   <= cnt_clip;
                        idx_reg <= '0;
                        err_reg <= job_data.err;
                        st_reg  <= job_data.err ? S_OUT : S_RD0;
                    end
                S_RD0:  st_reg <= S_CHK0;
                S_CHK0:
                    if (n_reg == IW'(1) || job_reg.tick <= rd_t_reg)
                        st_reg <= S_PICK;
                    else
                    begin
                        idx_reg <= n_reg - IW'(1);
                        st_reg  <= S_RDL;
                    end
                S_RDL:  st_reg <= S_CHKL;
                S_CHKL:
                    if (job_reg.tick >= rd_t_reg)
                        st_reg <= S_PICK;
                    else
                    begin
                        idx_reg <= IW'(1);
                        st_reg  <= S_SRCH;
                    end
                S_SRCH: st_reg <= S_SCHK;
                S_SCHK:
                    if (rd_t_reg >= job_reg.tick || idx_reg == n_reg - IW'(1))
                    begin
                        t1_reg  <= rd_t_reg;
                        b_reg   <= rd_v_reg;
                        idx_reg <= idx_reg - IW'(1);
                        st_reg  <= S_PREV;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                        st_reg  <= S_SRCH;
                    end
                S_PREV:
                    // wait for the earlier key's read, tracked by ov_reg
                    if (ov_reg)
                    begin
                        ov_reg   <= 1'b0;
                        a_reg    <= rd_v_reg;
                        span_reg <= t1_reg - rd_t_reg;
                        rem_reg  <= '0;
                        q_reg    <= '0;
                        bit_reg  <= 6'd47;
                        // el << 16 fed one bit at a time, top bit first
                        prod_reg <= {2'd0, job_reg.tick - rd_t_reg, 16'd0};
                        st_reg   <= (t1_reg > rd_t_reg) ? S_DIV : S_MUL;
                    end
                    else
                        ov_reg <= 1'b1;
                S_DIV:
                begin
                    // restoring divide of (el << 16) by span, 48 dividend bits
                    logic [48:0] r2;
                    r2 = {rem_reg[47:0], prod_reg[47]};
                    prod_reg <= {prod_reg[48:0], 1'b0};
                    if (r2 >= {17'd0, span_reg})
                    begin
                        rem_reg <= r2 - {17'd0, span_reg};
                        q_reg   <= {q_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= r2;
                        q_reg   <= {q_reg[15:0], 1'b0};
                    end
                    if (bit_reg == 6'd0)
                        st_reg <= S_MUL;
                    else
                        bit_reg <= bit_reg - 6'd1;
                end
                S_MUL:
                begin
                    prod_reg <= 50'(diff * $signed({1'b0, (span_reg != 0) ? q_reg : 17'd0}));
                    st_reg   <= S_ADD;
                end
                S_ADD:
                begin
                    res_reg <= a_reg + pfix[31:0];
                    st_reg  <= S_OUT;
                end
                S_PICK: st_reg <= S_ADD;
                S_OUT:
                begin
                    rsp_valid <= 1'b1;
                    st_reg    <= S_HOLD;
                end
                S_HOLD:
                    if (rsp_ready)
                    begin
                        rsp_valid <= 1'b0;
                        st_reg    <= S_IDLE;
                    end
                default: st_reg <= S_IDLE;
            endcase
            if (st_reg == S_PICK)
            begin
                a_reg    <= rd_v_reg;
                prod_reg <= '0;
            end
            if (st_reg == S_IDLE)
                ov_reg <= 1'b0;
        end
    end

    assign rsp_data.sample_value = err_reg ? '0 : res_reg;
    assign rsp_data.status       = err_reg ? ST_ERR : ST_OK;
endmodule
